FILE: rtl/bsa_pkg.sv
// ----------------------------------------------------------------------------
// bsa_pkg: shared definitions for the safety allocator
// Sizes, operation and verdict codes, the controller state encoding and the
// command and status bundles that pass between controller and datapath.
// ----------------------------------------------------------------------------
package bsa_pkg;

    localparam int PROCESSES   = 4;
    localparam int RESOURCES   = 3;
    localparam int COUNT_WIDTH = 8;

    localparam int PROC_W = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
    localparam int RES_W  = (RESOURCES > 1) ? $clog2(RESOURCES) : 1;

    localparam int OP_W    = 3;
    localparam int AMT_W   = 8;
    localparam int AMT_NUM = 3;

    typedef logic [COUNT_WIDTH-1:0] t_count;
    typedef logic [AMT_W-1:0]       t_amount;
    typedef logic [PROC_W-1:0]      t_proc_idx;

    localparam logic [OP_W-1:0] OP_LOAD_ALLOC = 3'd0;
    localparam logic [OP_W-1:0] OP_LOAD_NEED  = 3'd1;
    localparam logic [OP_W-1:0] OP_LOAD_AVAIL = 3'd2;
    localparam logic [OP_W-1:0] OP_REQUEST    = 3'd3;
    localparam logic [OP_W-1:0] OP_CHECK      = 3'd4;

    typedef enum logic [1:0] {
        VERDICT_SAFE    = 2'd0,
        VERDICT_UNSAFE  = 2'd1,
        VERDICT_INVALID = 2'd2
    } t_verdict;

    localparam logic KIND_SEQ     = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_REQ  = 5'b00010,
        S_INIT = 5'b00100,
        S_SCAN = 5'b01000,
        S_VERD = 5'b10000
    } t_state;

    typedef struct packed {
        logic     load_alloc;
        logic     load_need;
        logic     load_avail;
        logic     capture;
        logic     apply;
        logic     init;
        logic     pick;
        logic     next;
        logic     rollback;
        logic     emit_verdict;
        t_verdict verdict;
    } t_cmd;

    typedef struct packed {
        logic req_ok;
        logic fit;
        logic last_cand;
        logic all_done;
        logic out_free;
    } t_status;

endpackage

FILE: rtl/bankers_safety_allocator.sv
// ----------------------------------------------------------------------------
// bankers_safety_allocator: deadlock-avoidance resource allocator
// The input channel carries load, request and safety check items; the output
// channel carries safe-sequence entries followed by one verdict per run.
// Loads give no result. A check or a granted request
// loads the work vector from the available vector and then
// tests one candidate process per cycle against the need table, holding on
// a fitting candidate while the output register is full and restarting
// at process zero after each finished process.
// One item is worked on at a time; the input is ready only while idle.
// Results leave through a single output register; when the receiver stalls,
// the scan holds until that register is free, so no result is lost.
// A request that fails validation yields a single invalid verdict and changes
// nothing; an unsafe grant is rolled back as its verdict is issued.
// Reset clears all tables, the available vector and the output valid flag.
// ----------------------------------------------------------------------------
module bankers_safety_allocator (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [2:0] i_op,
    input  logic [1:0] i_proc,
    input  logic [1:0] i_res,
    input  logic [7:0] i_load_value,
    input  logic [7:0] i_amount_0,
    input  logic [7:0] i_amount_1,
    input  logic [7:0] i_amount_2,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_kind,
    output logic [1:0] o_seq_process,
    output logic [1:0] o_verdict,
    output logic       o_last
);

    bsa_pkg::t_cmd    w_cmd;
    bsa_pkg::t_status w_status;

    bsa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_op       (i_op),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    bsa_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_proc        (i_proc),
        .i_res         (i_res),
        .i_load_value  (i_load_value),
        .i_amount_0    (i_amount_0),
        .i_amount_1    (i_amount_1),
        .i_amount_2    (i_amount_2),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_kind        (o_kind),
        .o_seq_process (o_seq_process),
        .o_verdict     (o_verdict),
        .o_last        (o_last)
    );

endmodule

FILE: rtl/bsa_ctrl.sv
// ----------------------------------------------------------------------------
// bsa_ctrl: sequencing controller
// Decodes accepted items and steps the datapath through request validation,
// tentative grant, the safety scan, the verdict and the rollback.
// ----------------------------------------------------------------------------
module bsa_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [2:0]       i_op,
    input  bsa_pkg::t_status i_status,
    output bsa_pkg::t_cmd    o_cmd
);

    bsa_pkg::t_state r_state, n_state;
    logic            r_is_req, n_is_req;
    logic            w_accept;

    assign o_in_ready = (r_state == bsa_pkg::S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        n_is_req = r_is_req;
        o_cmd = '0;
        o_cmd.verdict = bsa_pkg::VERDICT_SAFE;
        unique case (r_state)
            bsa_pkg::S_IDLE: begin
                if (w_accept) begin
                    unique case (i_op)
                        bsa_pkg::OP_LOAD_ALLOC: o_cmd.load_alloc = 1'b1;
                        bsa_pkg::OP_LOAD_NEED:  o_cmd.load_need = 1'b1;
                        bsa_pkg::OP_LOAD_AVAIL: o_cmd.load_avail = 1'b1;
                        bsa_pkg::OP_REQUEST: begin
                            o_cmd.capture = 1'b1;
                            n_is_req = 1'b1;
                            n_state = bsa_pkg::S_REQ;
                        end
                        bsa_pkg::OP_CHECK: begin
                            n_is_req = 1'b0;
                            n_state = bsa_pkg::S_INIT;
                        end
                        default: n_state = bsa_pkg::S_IDLE;
                    endcase
                end
            end
            bsa_pkg::S_REQ: begin
                if (i_status.req_ok) begin
                    o_cmd.apply = 1'b1;
                    n_state = bsa_pkg::S_INIT;
                end else if (i_status.out_free) begin
                    o_cmd.emit_verdict = 1'b1;
                    o_cmd.verdict = bsa_pkg::VERDICT_INVALID;
                    n_state = bsa_pkg::S_IDLE;
                end
            end
            bsa_pkg::S_INIT: begin
                o_cmd.init = 1'b1;
                n_state = bsa_pkg::S_SCAN;
            end
            bsa_pkg::S_SCAN: begin
                if (i_status.all_done) begin
                    n_state = bsa_pkg::S_VERD;
                end else if (i_status.fit) begin
                    if (i_status.out_free) begin
                        o_cmd.pick = 1'b1;
                    end
                end else if (i_status.last_cand) begin
                    n_state = bsa_pkg::S_VERD;
                end else begin
                    o_cmd.next = 1'b1;
                end
            end
            bsa_pkg::S_VERD: begin
                if (i_status.out_free) begin
                    o_cmd.emit_verdict = 1'b1;
                    o_cmd.verdict = i_status.all_done ? bsa_pkg::VERDICT_SAFE
                                                      : bsa_pkg::VERDICT_UNSAFE;
                    o_cmd.rollback = r_is_req && !i_status.all_done;
                    n_state = bsa_pkg::S_IDLE;
                end
            end
            default: n_state = bsa_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bsa_pkg::S_IDLE;
            r_is_req <= 1'b0;
        end else begin
            r_state <= n_state;
            r_is_req <= n_is_req;
        end
    end

endmodule

FILE: rtl/bsa_datapath.sv
// ----------------------------------------------------------------------------
// bsa_datapath: tables, work vector and result register
// Holds the allocation and need tables, the available vector, the captured
// request, the scan state of the safety check and the output register.
// ----------------------------------------------------------------------------
module bsa_datapath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  bsa_pkg::t_cmd    i_cmd,
    output bsa_pkg::t_status o_status,
    input  logic [1:0]       i_proc,
    input  logic [1:0]       i_res,
    input  logic [7:0]       i_load_value,
    input  logic [7:0]       i_amount_0,
    input  logic [7:0]       i_amount_1,
    input  logic [7:0]       i_amount_2,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic             o_kind,
    output logic [1:0]       o_seq_process,
    output logic [1:0]       o_verdict,
    output logic             o_last
);

    localparam int SUM_W = bsa_pkg::COUNT_WIDTH + 1;
    localparam logic [SUM_W-1:0] COUNT_MAX = {1'b0, {bsa_pkg::COUNT_WIDTH{1'b1}}};

    bsa_pkg::t_count    r_alloc [bsa_pkg::PROCESSES][bsa_pkg::RESOURCES];
    bsa_pkg::t_count    r_need  [bsa_pkg::PROCESSES][bsa_pkg::RESOURCES];
    bsa_pkg::t_count    r_avail [bsa_pkg::RESOURCES];
    bsa_pkg::t_count    r_work  [bsa_pkg::RESOURCES];
    bsa_pkg::t_count    r_amt   [bsa_pkg::RESOURCES];
    bsa_pkg::t_amount   w_amt_in [bsa_pkg::AMT_NUM];
    bsa_pkg::t_amount   r_amt_raw [bsa_pkg::RESOURCES];
    bsa_pkg::t_proc_idx r_proc;
    logic               r_proc_ok;
    bsa_pkg::t_proc_idx r_cand;
    logic [bsa_pkg::PROCESSES-1:0] r_done;
    logic               r_out_valid;
    logic               r_kind;
    logic [1:0]         r_seq_process;
    logic [1:0]         r_verdict;
    logic               w_ld_proc_ok;
    logic               w_ld_res_ok;
    bsa_pkg::t_proc_idx w_ld_proc;
    logic [bsa_pkg::RES_W-1:0] w_ld_res;
    bsa_pkg::t_count    w_ld_val;
    logic               w_req_ok;
    logic               w_fit;
    logic [SUM_W-1:0]   w_sum [bsa_pkg::RESOURCES];

    assign w_amt_in[0] = i_amount_0;
    assign w_amt_in[1] = i_amount_1;
    assign w_amt_in[2] = i_amount_2;

    assign w_ld_proc_ok = int'(i_proc) < bsa_pkg::PROCESSES;
    assign w_ld_res_ok  = int'(i_res) < bsa_pkg::RESOURCES;
    assign w_ld_proc    = bsa_pkg::PROC_W'(i_proc);
    assign w_ld_res     = bsa_pkg::RES_W'(i_res);
    assign w_ld_val     = bsa_pkg::COUNT_WIDTH'(i_load_value);

    always_comb begin
        w_req_ok = r_proc_ok;
        for (int r = 0; r < bsa_pkg::RESOURCES; r++) begin
            if (32'(r_amt_raw[r]) > 32'(r_need[r_proc][r])) w_req_ok = 1'b0;
            if (32'(r_amt_raw[r]) > 32'(r_avail[r])) w_req_ok = 1'b0;
            if ((32'(r_alloc[r_proc][r]) + 32'(r_amt_raw[r])) > 32'(COUNT_MAX)) begin
                w_req_ok = 1'b0;
            end
        end
    end

    always_comb begin
        w_fit = !r_done[r_cand];
        for (int r = 0; r < bsa_pkg::RESOURCES; r++) begin
            if (r_need[r_cand][r] > r_work[r]) w_fit = 1'b0;
            w_sum[r] = SUM_W'(r_work[r]) + SUM_W'(r_alloc[r_cand][r]);
        end
    end

    assign o_status.req_ok    = w_req_ok;
    assign o_status.fit       = w_fit;
    assign o_status.last_cand = int'(r_cand) == bsa_pkg::PROCESSES - 1;
    assign o_status.all_done  = &r_done;
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < bsa_pkg::PROCESSES; p++) begin
                for (int r = 0; r < bsa_pkg::RESOURCES; r++) begin
                    r_alloc[p][r] <= '0;
                    r_need[p][r] <= '0;
                end
            end
            for (int r = 0; r < bsa_pkg::RESOURCES; r++) begin
                r_avail[r] <= '0;
            end
        end else begin
            if (i_cmd.load_alloc && w_ld_proc_ok && w_ld_res_ok) begin
                r_alloc[w_ld_proc][w_ld_res] <= w_ld_val;
            end
            if (i_cmd.load_need && w_ld_proc_ok && w_ld_res_ok) begin
                r_need[w_ld_proc][w_ld_res] <= w_ld_val;
            end
            if (i_cmd.load_avail && w_ld_res_ok) begin
                r_avail[w_ld_res] <= w_ld_val;
            end
            if (i_cmd.apply) begin
                for (int r = 0; r < bsa_pkg::RESOURCES; r++) begin
                    r_alloc[r_proc][r] <= r_alloc[r_proc][r] + r_amt[r];
                    r_need[r_proc][r] <= r_need[r_proc][r] - r_amt[r];
                    r_avail[r] <= r_avail[r] - r_amt[r];
                end
            end
            if (i_cmd.rollback) begin
                for (int r = 0; r < bsa_pkg::RESOURCES; r++) begin
                    r_alloc[r_proc][r] <= r_alloc[r_proc][r] - r_amt[r];
                    r_need[r_proc][r] <= r_need[r_proc][r] + r_amt[r];
                    r_avail[r] <= r_avail[r] + r_amt[r];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_proc <= w_ld_proc;
            r_proc_ok <= w_ld_proc_ok;
            for (int r = 0; r < bsa_pkg::RESOURCES; r++) begin
                r_amt_raw[r] <= w_amt_in[r];
                r_amt[r] <= bsa_pkg::COUNT_WIDTH'(w_amt_in[r]);
            end
        end
        if (i_cmd.init) begin
            r_done <= '0;
            r_cand <= '0;
            for (int r = 0; r < bsa_pkg::RESOURCES; r++) begin
                r_work[r] <= r_avail[r];
            end
        end
        if (i_cmd.next) begin
            r_cand <= r_cand + 1'b1;
        end
        if (i_cmd.pick) begin
            r_done[r_cand] <= 1'b1;
            r_cand <= '0;
            for (int r = 0; r < bsa_pkg::RESOURCES; r++) begin
                r_work[r] <= (w_sum[r] > COUNT_MAX) ? bsa_pkg::COUNT_WIDTH'(COUNT_MAX)
                                                     : bsa_pkg::COUNT_WIDTH'(w_sum[r]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.pick || i_cmd.emit_verdict) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pick) begin
            r_kind <= bsa_pkg::KIND_SEQ;
            r_seq_process <= 2'(r_cand);
            r_verdict <= bsa_pkg::VERDICT_SAFE;
        end else if (i_cmd.emit_verdict) begin
            r_kind <= bsa_pkg::KIND_VERDICT;
            r_seq_process <= '0;
            r_verdict <= i_cmd.verdict;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_kind        = r_kind;
    assign o_seq_process = r_seq_process;
    assign o_verdict     = r_verdict;
    assign o_last        = r_kind;

endmodule

FILE: tb/sv/bankers_safety_allocator_tb.sv
// ----------------------------------------------------------------------------
// bankers_safety_allocator_tb: self-checking bench for the safety allocator
// Directed items cover reset contents, ignored operations, the safety scan
// and every request outcome. Random traffic then runs with idle cycles on
// either side, a long output stall and a stretch without gaps. A predictor
// keeps its own copy of the tables and checks every result transfer in order.
// ----------------------------------------------------------------------------
module bankers_safety_allocator_tb;

    import bsa_pkg::*;

    localparam int COUNT_MAX    = (1 << COUNT_WIDTH) - 1;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 64;
    localparam int HOLD_CYCLES  = 300;

    localparam logic [OP_W-1:0] OP_UNUSED_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_UNUSED_LAST  = 3'd7;
    localparam logic [1:0]      RES_BEYOND      = 2'(RESOURCES);

    typedef struct packed {
        logic [OP_W-1:0]                op;
        logic [1:0]                     proc;
        logic [1:0]                     res;
        logic [7:0]                     load_value;
        logic [AMT_NUM-1:0][AMT_W-1:0]  amount;
    } t_item;

    typedef struct packed {
        logic       kind;
        logic [1:0] seq_process;
        t_verdict   verdict;
        logic       last;
    } t_outcome;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    logic [2:0] i_op;
    logic [1:0] i_proc;
    logic [1:0] i_res;
    logic [7:0] i_load_value;
    logic [7:0] i_amount_0;
    logic [7:0] i_amount_1;
    logic [7:0] i_amount_2;
    logic       o_out_valid;
    logic       i_out_ready;
    logic       o_kind;
    logic [1:0] o_seq_process;
    logic [1:0] o_verdict;
    logic       o_last;

    t_count   alloc_tab [PROCESSES][RESOURCES];
    t_count   need_tab  [PROCESSES][RESOURCES];
    t_count   avail_vec [RESOURCES];
    t_outcome outcome_q [$];
    t_outcome want;

    int tx_idle_pct;
    int rx_idle_pct;
    int hold_cycles;
    int error_count;
    int cycle_count;

    bankers_safety_allocator i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_op          (i_op),
        .i_proc        (i_proc),
        .i_res         (i_res),
        .i_load_value  (i_load_value),
        .i_amount_0    (i_amount_0),
        .i_amount_1    (i_amount_1),
        .i_amount_2    (i_amount_2),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_kind        (o_kind),
        .o_seq_process (o_seq_process),
        .o_verdict     (o_verdict),
        .o_last        (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        wait (cycle_count >= CYCLE_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        i_out_ready = 1'b0;
        hold_cycles = 0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                i_out_ready = 1'b0;
                hold_cycles--;
            end else begin
                i_out_ready = ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Predictor: table state and the safe-order scan
    // ------------------------------------------------------------------------
    function automatic bit scan_safe_order();
        int       work_vec [RESOURCES];
        bit       finished [PROCESSES];
        int       round, p, r, pick, fin_cnt, sum;
        bit       fits;
        t_verdict v;
        fin_cnt = 0;
        for (r = 0; r < RESOURCES; r++) work_vec[r] = int'(avail_vec[r]);
        for (p = 0; p < PROCESSES; p++) finished[p] = 1'b0;
        for (round = 0; round < PROCESSES; round++) begin
            pick = -1;
            for (p = 0; p < PROCESSES && pick < 0; p++) begin
                fits = !finished[p];
                for (r = 0; r < RESOURCES && fits; r++)
                    if (int'(need_tab[p][r]) > work_vec[r]) fits = 1'b0;
                if (fits) pick = p;
            end
            if (pick < 0) break;
            finished[pick] = 1'b1;
            fin_cnt++;
            outcome_q.push_back('{kind: KIND_SEQ, seq_process: 2'(pick),
                                  verdict: VERDICT_SAFE, last: 1'b0});
            for (r = 0; r < RESOURCES; r++) begin
                sum = work_vec[r] + int'(alloc_tab[pick][r]);
                work_vec[r] = (sum > COUNT_MAX) ? COUNT_MAX : sum;
            end
        end
        v = (fin_cnt == PROCESSES) ? VERDICT_SAFE : VERDICT_UNSAFE;
        outcome_q.push_back('{kind: KIND_VERDICT, seq_process: 2'd0,
                              verdict: v, last: 1'b1});
        return fin_cnt == PROCESSES;
    endfunction

    task automatic predict_banker(input t_item it);
        bit ok, safe;
        int r, amt;
        case (it.op)
            OP_LOAD_ALLOC: begin
                if (int'(it.proc) < PROCESSES && int'(it.res) < RESOURCES)
                    alloc_tab[it.proc][it.res] = t_count'(it.load_value);
            end
            OP_LOAD_NEED: begin
                if (int'(it.proc) < PROCESSES && int'(it.res) < RESOURCES)
                    need_tab[it.proc][it.res] = t_count'(it.load_value);
            end
            OP_LOAD_AVAIL: begin
                if (int'(it.res) < RESOURCES)
                    avail_vec[it.res] = t_count'(it.load_value);
            end
            OP_REQUEST: begin
                ok = int'(it.proc) < PROCESSES;
                for (r = 0; r < RESOURCES && ok; r++) begin
                    amt = int'(it.amount[r]);
                    if (amt > int'(need_tab[it.proc][r])) ok = 1'b0;
                    else if (amt > int'(avail_vec[r])) ok = 1'b0;
                    else if (int'(alloc_tab[it.proc][r]) + amt > COUNT_MAX) ok = 1'b0;
                end
                if (!ok) begin
                    outcome_q.push_back('{kind: KIND_VERDICT, seq_process: 2'd0,
                                          verdict: VERDICT_INVALID, last: 1'b1});
                end else begin
                    for (r = 0; r < RESOURCES; r++) begin
                        alloc_tab[it.proc][r] += t_count'(it.amount[r]);
                        need_tab[it.proc][r]  -= t_count'(it.amount[r]);
                        avail_vec[r]          -= t_count'(it.amount[r]);
                    end
                    safe = scan_safe_order();
                    if (!safe) begin
                        for (r = 0; r < RESOURCES; r++) begin
                            alloc_tab[it.proc][r] -= t_count'(it.amount[r]);
                            need_tab[it.proc][r]  += t_count'(it.amount[r]);
                            avail_vec[r]          += t_count'(it.amount[r]);
                        end
                    end
                end
            end
            OP_CHECK: begin
                safe = scan_safe_order();
            end
            default: begin
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------
    task automatic compare_field(input string fname, input int exp_val, input int got);
        if (exp_val != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, fname, exp_val, got);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (outcome_q.size() == 0) begin
                $display({"%0t: result transfer with nothing pending, expected none, ",
                          "actual kind %0d process %0d verdict %0d last %0d"},
                         $time, o_kind, o_seq_process, o_verdict, o_last);
                error_count++;
            end else begin
                want = outcome_q.pop_front();
                compare_field("kind", int'(want.kind), int'(o_kind));
                compare_field("seq_process", int'(want.seq_process), int'(o_seq_process));
                compare_field("verdict", int'(want.verdict), int'(o_verdict));
                compare_field("last", int'(want.last), int'(o_last));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    function automatic t_item make_item(input logic [OP_W-1:0] op, input int proc,
                                        input int res, input int value,
                                        input int a0, input int a1, input int a2);
        t_item it;
        it.op         = op;
        it.proc       = 2'(proc);
        it.res        = 2'(res);
        it.load_value = 8'(value);
        it.amount     = {8'(a2), 8'(a1), 8'(a0)};
        return it;
    endfunction

    task automatic send_item(input t_item it);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid   = 1'b1;
        i_op         = it.op;
        i_proc       = it.proc;
        i_res        = it.res;
        i_load_value = it.load_value;
        i_amount_0   = it.amount[0];
        i_amount_1   = it.amount[1];
        i_amount_2   = it.amount[2];
        do @(posedge i_clk); while (!o_in_ready);
        predict_banker(it);
    endtask

    task automatic send_load(input logic [OP_W-1:0] op, input int proc, input int res,
                             input int value);
        send_item(make_item(op, proc, res, value, $urandom_range(0, 255),
                            $urandom_range(0, 255), $urandom_range(0, 255)));
    endtask

    task automatic send_request(input int proc, input int a0, input int a1, input int a2);
        send_item(make_item(OP_REQUEST, proc, $urandom_range(0, 3),
                            $urandom_range(0, 255), a0, a1, a2));
    endtask

    task automatic send_check();
        send_item(make_item(OP_CHECK, $urandom_range(0, 3), $urandom_range(0, 3),
                            $urandom_range(0, 255), $urandom_range(0, 255),
                            $urandom_range(0, 255), $urandom_range(0, 255)));
    endtask

    task automatic test_reset_state_and_ignored_ops();
        logic [OP_W-1:0] op;
        send_check();
        for (op = OP_UNUSED_FIRST; op <= OP_UNUSED_LAST && op >= OP_UNUSED_FIRST; op++)
            send_item(make_item(op, $urandom_range(0, 3), $urandom_range(0, 3),
                                $urandom_range(0, 255), $urandom_range(0, 255),
                                $urandom_range(0, 255), $urandom_range(0, 255)));
        send_load(OP_LOAD_NEED, 1, RES_BEYOND, 255);
        send_load(OP_LOAD_AVAIL, 2, RES_BEYOND, 255);
        send_check();
    endtask

    task automatic test_safety_scan();
        send_load(OP_LOAD_NEED, 3, 2, 255);
        send_check();
        send_load(OP_LOAD_ALLOC, 0, 2, 255);
        send_load(OP_LOAD_AVAIL, $urandom_range(0, 3), 2, 200);
        send_check();
    endtask

    task automatic test_request_validation();
        send_request(1, 255, 255, 255);
        send_load(OP_LOAD_NEED, 1, 0, 10);
        send_load(OP_LOAD_AVAIL, $urandom_range(0, 3), 0, 5);
        send_request(1, 6, 0, 0);
        send_load(OP_LOAD_AVAIL, $urandom_range(0, 3), 0, 10);
        send_load(OP_LOAD_ALLOC, 1, 0, 250);
        send_request(1, 6, 0, 0);
        send_load(OP_LOAD_ALLOC, 1, 0, 0);
        send_request(1, 5, 0, 0);
        send_load(OP_LOAD_ALLOC, 0, 2, 0);
        send_request(3, 0, 0, 200);
        send_request(3, 0, 0, 200);
    endtask

    function automatic int pick_load_value();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) return $urandom_range(0, 12);
        if (roll < 85) return $urandom_range(240, 255);
        return $urandom_range(0, 255);
    endfunction

    task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int count);
        t_item it;
        int    done_cnt, roll, r, pick;
        bit    counts;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        done_cnt    = 0;
        while (done_cnt < count) begin
            roll   = $urandom_range(0, 99);
            counts = 1'b1;
            if (roll < 45) begin
                it = make_item(OP_REQUEST, $urandom_range(0, 3), $urandom_range(0, 3),
                               $urandom_range(0, 255), 0, 0, 0);
                for (r = 0; r < AMT_NUM; r++) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 60 && r < RESOURCES)
                        it.amount[r] = 8'($urandom_range(0, int'(need_tab[it.proc][r])));
                    else if (pick < 85)
                        it.amount[r] = 8'($urandom_range(0, 3));
                    else
                        it.amount[r] = 8'($urandom_range(0, 255));
                end
            end else if (roll < 57) begin
                it = make_item(OP_CHECK, $urandom_range(0, 3), $urandom_range(0, 3),
                               $urandom_range(0, 255), $urandom_range(0, 255),
                               $urandom_range(0, 255), $urandom_range(0, 255));
            end else if (roll < 95) begin
                it = make_item(3'($urandom_range(int'(OP_LOAD_ALLOC), int'(OP_LOAD_AVAIL))),
                               $urandom_range(0, 3),
                               ($urandom_range(0, 99) < 8) ? int'(RES_BEYOND)
                                                           : $urandom_range(0, RESOURCES - 1),
                               pick_load_value(), $urandom_range(0, 255),
                               $urandom_range(0, 255), $urandom_range(0, 255));
                counts = int'(it.res) < RESOURCES;
            end else begin
                it = make_item(3'($urandom_range(int'(OP_UNUSED_FIRST), int'(OP_UNUSED_LAST))),
                               $urandom_range(0, 3), $urandom_range(0, 3),
                               $urandom_range(0, 255), $urandom_range(0, 255),
                               $urandom_range(0, 255), $urandom_range(0, 255));
                counts = 1'b0;
            end
            send_item(it);
            if (counts) done_cnt++;
        end
    endtask

    task automatic test_output_backpressure();
        int i;
        tx_idle_pct = 0;
        hold_cycles = HOLD_CYCLES;
        for (i = 0; i < 12; i++) begin
            if (i % 3 == 2)
                send_request($urandom_range(0, 3), $urandom_range(0, 1),
                             $urandom_range(0, 1), $urandom_range(0, 1));
            else
                send_check();
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_op         = OP_LOAD_ALLOC;
        i_proc       = '0;
        i_res        = '0;
        i_load_value = '0;
        i_amount_0   = '0;
        i_amount_1   = '0;
        i_amount_2   = '0;
        tx_idle_pct  = 22;
        rx_idle_pct  = 54;
        error_count  = 0;
        for (int p = 0; p < PROCESSES; p++) begin
            for (int r = 0; r < RESOURCES; r++) begin
                alloc_tab[p][r] = '0;
                need_tab[p][r]  = '0;
            end
        end
        for (int r = 0; r < RESOURCES; r++) avail_vec[r] = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_state_and_ignored_ops();
        test_safety_scan();
        test_request_validation();
        test_random_traffic(22, 54, 135);
        test_random_traffic(54, 22, 135);
        test_output_backpressure();
        test_random_traffic(0, 0, 125);

        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (outcome_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && outcome_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

FILE: bankers_safety_allocator.f
rtl/bsa_pkg.sv
rtl/bsa_ctrl.sv
rtl/bsa_datapath.sv
rtl/bankers_safety_allocator.sv
tb/sv/bankers_safety_allocator_tb.sv
